// ===== rtl/core/motor_frame_deframer_odometry_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the motor frame deframer
// Concurrent checks that vanish when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MOTOR_FRAME_DEFRAMER_ODOMETRY_ASSERT_SVH
`define MOTOR_FRAME_DEFRAMER_ODOMETRY_ASSERT_SVH

`ifndef SYNTHESIS
`define MFDO_ASSERT_AT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MFDO_ASSERT(lbl, prop, msg) \
   `MFDO_ASSERT_AT(lbl, clock, reset, prop, msg)
`else
`define MFDO_ASSERT_AT(lbl, clk, rst, prop, msg)
`define MFDO_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== rtl/core/mfdo_pkg.sv =====
// ---------------------------------------------------------------------------
// mfdo_pkg
// Frame layout constants and shared types of the motor frame deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package mfdo_pkg;

   localparam int AXES          = 4;
   localparam int FRAME_BYTES   = 42;
   localparam int PAYLOAD_BYTES = FRAME_BYTES - 2;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
   localparam int IDX_W         = 6;
   localparam int RAM_AW        = IDX_W + 1;
   localparam int AXIS_W        = 2;

   // bit offsets inside the payload word, byte 1 at bit 0
   localparam int TGT_BASE  = 0;
   localparam int ODO_BASE  = 2 * AXES * 8;
   localparam int REAL_BASE = ODO_BASE + 4 * AXES * 8;

   localparam logic [7:0] HEADER_BYTE  = 8'h23;
   localparam logic [7:0] TRAILER_BYTE = 8'h21;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef enum logic [2:0] {
      EMIT_IDLE,
      EMIT_SUM1,
      EMIT_SUM2,
      EMIT_DIV,
      EMIT_OUT
   } emit_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/motor_frame_deframer_odometry.sv =====
// ---------------------------------------------------------------------------
// motor_frame_deframer_odometry
// Receives 42-byte '#'...'!' motor frames and emits four axis words each.
// ---------------------------------------------------------------------------
// One serial byte is taken per cycle while req_tready is high. Bytes go
// into one of two frame banks of a single-port-write RAM; a frame with a
// good trailer hands its bank to the readout, which unpacks it over the RAM
// read port, then runs the odometry adds and the divide, after which the
// four axis words go out at one per cycle while rsp_tready is high. A frame
// with a bad trailer frees its bank at once. req_tready drops only while
// hunting for a header with both banks still waiting for readout, which
// happens only when the result side stalls. No clearing pass follows reset.
`default_nettype none

`include "motor_frame_deframer_odometry_assert.svh"

module motor_frame_deframer_odometry
   import mfdo_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,   // rx_byte
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [143:0]      rsp_tdata,   // target_speed, odometer, real_speed, odo_x, odo_y
   output logic [1:0]        rsp_tuser,   // axis
   output logic              rsp_tlast
);

   logic [1:0]           full;
   release_type          rel;
   logic                 wr_en;
   logic [RAM_AW-1:0]    wr_addr;
   logic [7:0]           wr_data;
   logic                 rd_en;
   logic [RAM_AW-1:0]    rd_addr;
   logic [7:0]           rd_data;
   logic                 frame_valid;
   logic [PAYLOAD_W-1:0] frame_data;
   logic                 frame_take;

   mfdo_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rel        (rel),
      .full       (full),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   mfdo_frame_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mfdo_drain u_drain (
      .clock       (clock),
      .reset       (reset),
      .full        (full),
      .rel         (rel),
      .rd_en       (rd_en),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .frame_valid (frame_valid),
      .frame_data  (frame_data),
      .frame_take  (frame_take)
   );

   mfdo_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (frame_valid),
      .frame_data  (frame_data),
      .frame_take  (frame_take),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   `MFDO_ASSERT(a_release_full, rel.valid |-> full[rel.bank], "bank released while not full")
   `MFDO_ASSERT(a_release_clears, rel.valid |=> !full[$past(rel.bank)], "released bank still full")
   `MFDO_ASSERT(a_last_axis, rsp_tvalid |-> (rsp_tlast == (rsp_tuser == 2'd3)), "tlast off axis 3")

endmodule

`default_nettype wire

// ===== rtl/core/mfdo_frame_ram.sv =====
// ---------------------------------------------------------------------------
// mfdo_frame_ram
// Two-bank frame byte store, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module mfdo_frame_ram
   import mfdo_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [RAM_AW-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [RAM_AW-1:0] rd_addr,
   output logic [7:0]             rd_data
);

   logic [7:0] mem [2**RAM_AW];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/mfdo_rx.sv =====
// ---------------------------------------------------------------------------
// mfdo_rx
// Header hunt, byte collection into the current bank and trailer check.
// ---------------------------------------------------------------------------
`default_nettype none

module mfdo_rx
   import mfdo_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,
   input  wire release_type       rel,
   output logic [1:0]             full,
   output logic                   wr_en,
   output logic [RAM_AW-1:0]      wr_addr,
   output logic [7:0]             wr_data
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             bank_ff, bank_in;
   logic [1:0]       full_ff, full_in;
   logic             hunting;
   logic             store;

   assign hunting    = (idx_ff == '0);
   assign req_tready = !(hunting && full_ff[bank_ff]);
   assign store      = req_tvalid && req_tready && !(hunting && req_tdata != HEADER_BYTE);

   assign wr_en   = store;
   assign wr_addr = {bank_ff, idx_ff};
   assign wr_data = req_tdata;
   assign full    = full_ff;

   always_comb begin
      idx_in  = idx_ff;
      bank_in = bank_ff;
      full_in = full_ff;
      if (rel.valid) begin
         full_in[rel.bank] = 1'b0;
      end
      if (store) begin
         if (idx_ff == IDX_W'(FRAME_BYTES - 1)) begin
            idx_in = '0;
            if (req_tdata == TRAILER_BYTE) begin
               full_in[bank_ff] = 1'b1;
               bank_in          = ~bank_ff;
            end
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         bank_ff <= 1'b0;
         full_ff <= '0;
      end else begin
         idx_ff  <= idx_in;
         bank_ff <= bank_in;
         full_ff <= full_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mfdo_drain.sv =====
// ---------------------------------------------------------------------------
// mfdo_drain
// Reads the payload bytes of a full bank and assembles the payload word.
// ---------------------------------------------------------------------------
`default_nettype none

module mfdo_drain
   import mfdo_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [1:0]        full,
   output release_type            rel,
   output logic                   rd_en,
   output logic [RAM_AW-1:0]      rd_addr,
   input  wire logic [7:0]        rd_data,
   output logic                   frame_valid,
   output logic [PAYLOAD_W-1:0]   frame_data,
   input  wire logic              frame_take
);

   logic                 active_ff, active_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic                 bank_ff, bank_in;
   logic                 dv_ff, dv_in;
   logic                 dlast_ff, dlast_in;
   logic                 fvalid_ff, fvalid_in;
   logic [PAYLOAD_W-1:0] frame_ff;
   logic                 last_rd;

   assign last_rd = active_ff && (idx_ff == IDX_W'(PAYLOAD_BYTES));

   assign rd_en     = active_ff;
   assign rd_addr   = {bank_ff, idx_ff};
   assign rel.valid = last_rd;
   assign rel.bank  = bank_ff;

   assign frame_valid = fvalid_ff;
   assign frame_data  = frame_ff;

   always_comb begin
      active_in = active_ff;
      idx_in    = idx_ff;
      bank_in   = bank_ff;
      dv_in     = active_ff;
      dlast_in  = last_rd;
      fvalid_in = fvalid_ff;
      if (frame_take) begin
         fvalid_in = 1'b0;
      end
      if (dv_ff && dlast_ff) begin
         fvalid_in = 1'b1;
      end
      if (active_ff) begin
         if (last_rd) begin
            active_in = 1'b0;
            bank_in   = ~bank_ff;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (!dv_ff && (!fvalid_ff || frame_take) && full[bank_ff]) begin
         // start at byte 1 once the held word is taken or none is held
         active_in = 1'b1;
         idx_in    = IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
         bank_ff   <= 1'b0;
         dv_ff     <= 1'b0;
         dlast_ff  <= 1'b0;
         fvalid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
         bank_ff   <= bank_in;
         dv_ff     <= dv_in;
         dlast_ff  <= dlast_in;
         fvalid_ff <= fvalid_in;
      end
   end

   // byte 1 ends up at the bottom after the last shift
   always_ff @(posedge clock) begin
      if (dv_ff) begin
         frame_ff <= {rd_data, frame_ff[PAYLOAD_W-1:8]};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mfdo_emit.sv =====
// ---------------------------------------------------------------------------
// mfdo_emit
// Odometry sums and divide in states SUM1, SUM2 and DIV, then one result word per axis.
// ---------------------------------------------------------------------------
`default_nettype none

module mfdo_emit
   import mfdo_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              frame_valid,
   input  wire logic [PAYLOAD_W-1:0] frame_data,
   output logic                   frame_take,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output logic [143:0]           rsp_tdata,
   output logic [AXIS_W-1:0]      rsp_tuser,
   output logic                   rsp_tlast
);

   localparam logic signed [33:0] SAT_MAX = 34'sd2147483647;
   localparam logic signed [33:0] SAT_MIN = -34'sd2147483648;

   // truncating divide by four, then clamp
   function automatic logic [31:0] sat_div4(input logic signed [33:0] s);
      logic signed [33:0] adj;
      logic signed [33:0] q;
      adj = s + (s[33] ? 34'sd3 : 34'sd0);
      q   = adj >>> 2;
      if (q > SAT_MAX) begin
         return 32'h7fff_ffff;
      end else if (q < SAT_MIN) begin
         return 32'h8000_0000;
      end
      return q[31:0];
   endfunction

   emit_state_type       state_ff, state_in;
   logic [AXIS_W-1:0]    axis_ff, axis_in;
   logic [PAYLOAD_W-1:0] hold_ff;
   logic signed [32:0]   pa_ff, pb_ff, qa_ff, qb_ff;
   logic signed [33:0]   sx_ff, sy_ff;
   logic [31:0]          ox_ff, oy_ff;
   logic                 load;
   logic [15:0]          tgt  [AXES];
   logic [31:0]          odo  [AXES];
   logic [31:0]          real_spd [AXES];

   always_comb begin
      for (int k = 0; k < AXES; k++) begin
         tgt[k]      = hold_ff[TGT_BASE + 16 * k +: 16];
         odo[k]      = hold_ff[ODO_BASE + 32 * k +: 32];
         real_spd[k] = hold_ff[REAL_BASE + 32 * k +: 32];
      end
   end

   always_comb begin
      state_in = state_ff;
      axis_in  = axis_ff;
      load     = 1'b0;
      case (state_ff)
         EMIT_IDLE: begin
            if (frame_valid) begin
               load     = 1'b1;
               state_in = EMIT_SUM1;
            end
         end
         EMIT_SUM1: state_in = EMIT_SUM2;
         EMIT_SUM2: state_in = EMIT_DIV;
         EMIT_DIV: begin
            state_in = EMIT_OUT;
            axis_in  = '0;
         end
         EMIT_OUT: begin
            if (rsp_tready) begin
               if (axis_ff == AXIS_W'(AXES - 1)) begin
                  if (frame_valid) begin
                     load     = 1'b1;
                     state_in = EMIT_SUM1;
                  end else begin
                     state_in = EMIT_IDLE;
                  end
               end else begin
                  axis_in = axis_ff + 1'b1;
               end
            end
         end
         default: state_in = EMIT_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff <= frame_data;
      end
      if (state_ff == EMIT_SUM1) begin
         pa_ff <= $signed({odo[2][31], odo[2]}) - $signed({odo[0][31], odo[0]});
         pb_ff <= $signed({odo[3][31], odo[3]}) - $signed({odo[1][31], odo[1]});
         qa_ff <= $signed({odo[0][31], odo[0]}) - $signed({odo[1][31], odo[1]});
         qb_ff <= $signed({odo[2][31], odo[2]}) - $signed({odo[3][31], odo[3]});
      end
      if (state_ff == EMIT_SUM2) begin
         sx_ff <= $signed({pa_ff[32], pa_ff}) + $signed({pb_ff[32], pb_ff});
         sy_ff <= $signed({qa_ff[32], qa_ff}) + $signed({qb_ff[32], qb_ff});
      end
      if (state_ff == EMIT_DIV) begin
         ox_ff <= sat_div4(sx_ff);
         oy_ff <= sat_div4(sy_ff);
      end
   end

   assign frame_take = load;
   assign rsp_tvalid = (state_ff == EMIT_OUT);
   assign rsp_tuser  = axis_ff;
   assign rsp_tlast  = (axis_ff == AXIS_W'(AXES - 1));
   assign rsp_tdata  = {oy_ff, ox_ff, real_spd[axis_ff], odo[axis_ff], tgt[axis_ff]};

endmodule

`default_nettype wire
